[rtl/crc_checked_frame_receiver_assert.svh]
// Assertion macros used by the frame receiver top level.
`ifndef CRC_CHECKED_FRAME_RECEIVER_ASSERT_SVH
`define CRC_CHECKED_FRAME_RECEIVER_ASSERT_SVH

// Same-cycle implication, disabled while reset is applied.
`define CCFR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is applied.
`define CCFR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/ccfr_pkg.sv]
// Package with constants, types and helper functions of the frame receiver.
package ccfr_pkg;

    localparam int BUFFER_DEPTH = 512;
    localparam int ADDR_W       = $clog2(BUFFER_DEPTH);
    localparam int CNT_W        = $clog2(BUFFER_DEPTH + 1);
    localparam int STORE_DEPTH  = 256;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_MSB  = 16'h8000;

    // Header pair, type, length and two CRC bytes.
    localparam int MIN_FRAME = 6;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_FIRST      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_SECOND     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STATE_TYPE_CODE   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STATE_PAYLOAD_LEN = 2'd3;

    localparam logic [7:0] RST_HEADER_FIRST      = 8'd170;
    localparam logic [7:0] RST_HEADER_SECOND     = 8'd85;
    localparam logic [7:0] RST_STATE_TYPE_CODE   = 8'd1;
    localparam logic [7:0] RST_STATE_PAYLOAD_LEN = 8'd32;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [CNT_W-1:0]  cnt_t;

    typedef struct packed {
        logic       en;
        logic [7:0] addr;
        logic [7:0] data;
    } store_wr_t;

    // Position of a byte at a given offset from the queue head, wrapped round the ring.
    function automatic addr_t wrap_add(addr_t base, cnt_t off);
        logic [CNT_W:0] sum;
        sum = {1'b0, {(CNT_W - ADDR_W){1'b0}}, base} + {1'b0, off};
        if (sum >= (CNT_W + 1)'(BUFFER_DEPTH))
        begin
            sum = sum - (CNT_W + 1)'(BUFFER_DEPTH);
        end
        return sum[ADDR_W-1:0];
    endfunction

    // CRC-16 update with one byte, most significant bit first.
    function automatic logic [15:0] crc_byte(logic [15:0] crc_in, logic [7:0] data);
        logic [15:0] c;
        c = crc_in ^ {data, 8'h00};
        for (int b = 0; b < 8; b++)
        begin
            if ((c & CRC_MSB) != 16'h0000)
            begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

[rtl/ccfr_in_if.sv]
// Input channel: received bytes and store read requests.
interface ccfr_in_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [7:0] rx_byte;
    logic [7:0] read_index;

    modport source (output valid, output op, output rx_byte, output read_index, input ready);
    modport sink (input valid, input op, input rx_byte, input read_index, output ready);
endinterface

[rtl/ccfr_out_if.sv]
// Result channel: frame flag and store read data.
interface ccfr_out_if;
    logic       valid;
    logic       ready;
    logic       state_frame_seen;
    logic [7:0] read_data;

    modport source (output valid, output state_frame_seen, output read_data, input ready);
    modport sink (input valid, input state_frame_seen, input read_data, output ready);
endinterface

[rtl/ccfr_ram.sv]
// Simple dual-port RAM with one write port and a registered read port.
module ccfr_ram #(
    parameter int DEPTH = 512,
    parameter int WIDTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/ccfr_store.sv]
// Kept payload store with per-entry valid bits, so unwritten entries read as zero.
module ccfr_store (
    input  logic                clk,
    input  logic                rst_n,
    input  ccfr_pkg::store_wr_t wr,
    input  logic [7:0]          raddr,
    output logic [7:0]          rdata
);
    import ccfr_pkg::*;

    logic [7:0]             mem [STORE_DEPTH];
    logic [STORE_DEPTH-1:0] valid_reg;
    logic [7:0]             data_reg;
    logic                   hit_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        data_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                valid_reg[wr.addr] <= 1'b1;
            end
            hit_reg <= valid_reg[raddr];
        end
    end

    assign rdata = hit_reg ? data_reg : 8'h00;

endmodule

[rtl/crc_checked_frame_receiver.sv]
// Top level of the CRC-checked frame receiver: queue sequencer, byte queue and payload store.
//
//   Channel   Dir  Handshake         Beat contents
//   item      in   valid/ready       op, rx_byte, read_index
//   result    out  valid/ready       state_frame_seen, read_data
//   cfg       in   cfg_we only       cfg_index, cfg_wdata
//
// A read beat passes through S_RDWAIT and S_DONE before the output hand-over. A pushed byte
// goes through S_CHECK to S_DONE when fewer than six bytes wait; otherwise the sequencer walks
// the byte queue one RAM read a cycle, checks each frame that it finds and copies a kept payload
// into the store. The single read port of the queue RAM sets this pace.
// Reset is asynchronous and active low; the store reads as zero until written.
// Input is taken only while the sequencer is idle; a result waiting at the output does not
// stop a new beat being accepted.
module crc_checked_frame_receiver (
    input  logic                              clk,
    input  logic                              rst_n,
    ccfr_in_if.sink                           item,
    ccfr_out_if.source                        result,
    input  logic                              cfg_we,
    input  logic [ccfr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [7:0]                        cfg_wdata
);
    import ccfr_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_SCAN_A, S_SCAN, S_AFTER, S_TYPE, S_LEN, S_PAY,
        S_CRC_HI, S_CRC_LO, S_COPY, S_RDWAIT, S_DONE
    } state_t;

    state_t      state_reg, state_next;
    addr_t       start_reg, start_next;
    cnt_t        count_reg, count_next;
    cnt_t        off_reg, off_next;
    cnt_t        idx_reg, idx_next;
    logic [7:0]  prev_reg, prev_next;
    logic [7:0]  type_reg, type_next;
    logic [7:0]  plen_reg, plen_next;
    logic [7:0]  have_reg, have_next;
    logic [15:0] crc_reg, crc_next;
    logic        seen_reg, seen_next;
    logic [7:0]  data_reg, data_next;
    logic        out_valid_reg, out_valid_next;
    logic        out_seen_reg, out_seen_next;
    logic [7:0]  out_data_reg, out_data_next;
    logic [7:0]  hf_reg, hs_reg, code_reg, len_reg;

    cnt_t        rd_off;
    cnt_t        flen;
    logic        accept;
    logic        full;
    logic        ram_we;
    addr_t       ram_waddr;
    logic [7:0]  ram_rdata;
    store_wr_t   store_wr;
    logic [7:0]  store_rdata;

    assign accept = item.valid && item.ready;
    assign full   = (count_reg == CNT_W'(BUFFER_DEPTH));
    assign flen   = CNT_W'(MIN_FRAME) + CNT_W'(plen_reg);

    // When the queue is full the oldest byte is overwritten in place.
    assign ram_we    = accept && (item.op == OP_PUSH);
    assign ram_waddr = full ? start_reg : wrap_add(start_reg, count_reg);

    ccfr_ram #(
        .DEPTH (BUFFER_DEPTH),
        .WIDTH (8)
    ) u_queue (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (item.rx_byte),
        .raddr (wrap_add(start_reg, rd_off)),
        .rdata (ram_rdata)
    );

    ccfr_store u_store (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (store_wr),
        .raddr (item.read_index),
        .rdata (store_rdata)
    );

    assign item.ready              = (state_reg == S_IDLE);
    assign result.valid            = out_valid_reg;
    assign result.state_frame_seen = out_seen_reg;
    assign result.read_data        = out_data_reg;

    // Each state that sets rd_off finds that byte on ram_rdata in the following state.
    always_comb
    begin
        state_next     = state_reg;
        start_next     = start_reg;
        count_next     = count_reg;
        off_next       = off_reg;
        idx_next       = idx_reg;
        prev_next      = prev_reg;
        type_next      = type_reg;
        plen_next      = plen_reg;
        have_next      = have_reg;
        crc_next       = crc_reg;
        seen_next      = seen_reg;
        data_next      = data_reg;
        out_valid_next = out_valid_reg && !result.ready;
        out_seen_next  = out_seen_reg;
        out_data_next  = out_data_reg;
        rd_off         = '0;
        store_wr       = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (item.op == OP_READ)
                    begin
                        state_next = S_RDWAIT;
                    end
                    else
                    begin
                        seen_next  = 1'b0;
                        data_next  = 8'h00;
                        state_next = S_CHECK;
                        if (full)
                        begin
                            start_next = wrap_add(start_reg, CNT_W'(1));
                        end
                        else
                        begin
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                end
            end
            S_CHECK:
            begin
                if (count_reg >= CNT_W'(MIN_FRAME))
                begin
                    rd_off     = '0;
                    state_next = S_SCAN_A;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_SCAN_A:
            begin
                prev_next  = ram_rdata;
                rd_off     = CNT_W'(1);
                off_next   = CNT_W'(1);
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                // prev_reg holds the byte before off_reg; the pair is tested at off_reg - 1.
                if (prev_reg == hf_reg && ram_rdata == hs_reg)
                begin
                    start_next = wrap_add(start_reg, off_reg - CNT_W'(1));
                    count_next = count_reg - (off_reg - CNT_W'(1));
                    state_next = S_AFTER;
                end
                else if (off_reg + CNT_W'(1) >= count_reg)
                begin
                    start_next = '0;
                    count_next = '0;
                    state_next = S_DONE;
                end
                else
                begin
                    prev_next = ram_rdata;
                    rd_off    = off_reg + CNT_W'(1);
                    off_next  = off_reg + CNT_W'(1);
                end
            end
            S_AFTER:
            begin
                if (count_reg < CNT_W'(MIN_FRAME))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    rd_off     = CNT_W'(2);
                    state_next = S_TYPE;
                end
            end
            S_TYPE:
            begin
                type_next  = ram_rdata;
                crc_next   = crc_byte(CRC_INIT, ram_rdata);
                rd_off     = CNT_W'(3);
                state_next = S_LEN;
            end
            S_LEN:
            begin
                plen_next = ram_rdata;
                crc_next  = crc_byte(crc_reg, ram_rdata);
                if (count_reg < CNT_W'(MIN_FRAME) + CNT_W'(ram_rdata))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    rd_off     = CNT_W'(4);
                    idx_next   = CNT_W'(4);
                    state_next = (ram_rdata == 8'h00) ? S_CRC_HI : S_PAY;
                end
            end
            S_PAY:
            begin
                crc_next = crc_byte(crc_reg, ram_rdata);
                if (idx_reg == CNT_W'(3) + CNT_W'(plen_reg))
                begin
                    rd_off     = CNT_W'(4) + CNT_W'(plen_reg);
                    state_next = S_CRC_HI;
                end
                else
                begin
                    idx_next = idx_reg + CNT_W'(1);
                    rd_off   = idx_reg + CNT_W'(1);
                end
            end
            S_CRC_HI:
            begin
                have_next  = ram_rdata;
                rd_off     = CNT_W'(5) + CNT_W'(plen_reg);
                state_next = S_CRC_LO;
            end
            S_CRC_LO:
            begin
                state_next = S_CHECK;
                if ({have_reg, ram_rdata} != crc_reg)
                begin
                    // Bad check: give up only the first header byte and scan again.
                    start_next = wrap_add(start_reg, CNT_W'(1));
                    count_next = count_reg - CNT_W'(1);
                end
                else if (type_reg == code_reg && plen_reg == len_reg && plen_reg != 8'h00)
                begin
                    seen_next  = 1'b1;
                    idx_next   = '0;
                    rd_off     = CNT_W'(4);
                    state_next = S_COPY;
                end
                else
                begin
                    if (type_reg == code_reg && plen_reg == len_reg)
                    begin
                        seen_next = 1'b1;
                    end
                    start_next = wrap_add(start_reg, flen);
                    count_next = count_reg - flen;
                end
            end
            S_COPY:
            begin
                store_wr.en   = 1'b1;
                store_wr.addr = idx_reg[7:0];
                store_wr.data = ram_rdata;
                if (idx_reg[7:0] == plen_reg - 8'd1)
                begin
                    start_next = wrap_add(start_reg, flen);
                    count_next = count_reg - flen;
                    state_next = S_CHECK;
                end
                else
                begin
                    idx_next = idx_reg + CNT_W'(1);
                    rd_off   = idx_reg + CNT_W'(5);
                end
            end
            S_RDWAIT:
            begin
                seen_next  = 1'b0;
                data_next  = store_rdata;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next = 1'b1;
                    out_seen_next  = seen_reg;
                    out_data_next  = data_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            start_reg     <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            hf_reg        <= RST_HEADER_FIRST;
            hs_reg        <= RST_HEADER_SECOND;
            code_reg      <= RST_STATE_TYPE_CODE;
            len_reg       <= RST_STATE_PAYLOAD_LEN;
            off_reg       <= '0;
            idx_reg       <= '0;
            prev_reg      <= '0;
            type_reg      <= '0;
            plen_reg      <= '0;
            have_reg      <= '0;
            crc_reg       <= '0;
            seen_reg      <= 1'b0;
            data_reg      <= '0;
            out_seen_reg  <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            start_reg     <= start_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            off_reg       <= off_next;
            idx_reg       <= idx_next;
            prev_reg      <= prev_next;
            type_reg      <= type_next;
            plen_reg      <= plen_next;
            have_reg      <= have_next;
            crc_reg       <= crc_next;
            seen_reg      <= seen_next;
            data_reg      <= data_next;
            out_seen_reg  <= out_seen_next;
            out_data_reg  <= out_data_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_HEADER_FIRST:      hf_reg   <= cfg_wdata;
                    CFG_HEADER_SECOND:     hs_reg   <= cfg_wdata;
                    CFG_STATE_TYPE_CODE:   code_reg <= cfg_wdata;
                    CFG_STATE_PAYLOAD_LEN: len_reg  <= cfg_wdata;
                    default:               hf_reg   <= hf_reg;
                endcase
            end
        end
    end

`include "crc_checked_frame_receiver_assert.svh"

    `CCFR_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_W'(BUFFER_DEPTH), "queue count beyond depth")
    `CCFR_ASSERT_NOW(a_start_bound, clk, rst_n, 1'b1, start_reg < ADDR_W'(BUFFER_DEPTH - 1) || start_reg == ADDR_W'(BUFFER_DEPTH - 1), "queue head beyond depth")
    `CCFR_ASSERT_NEXT(a_push_counted, clk, rst_n, accept && item.op == OP_PUSH, count_reg != '0, "pushed byte not counted")
    `CCFR_ASSERT_NOW(a_copy_only_kept, clk, rst_n, store_wr.en, seen_reg && plen_reg == len_reg, "store written outside a kept frame")

endmodule
